// ----- rtl/core/scif_pkg.sv -----
// ----------------------------------------------------------------------------
// scif_pkg
// Shared types and constants of the integer field scanner: transaction
// payloads, configuration layout, scan phases and character codes.
// ----------------------------------------------------------------------------
package scif_pkg;

	// accumulator width default
	localparam int VALUE_BITS_DEF = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_KIND        = 2'd0;
	localparam logic [1:0] CFG_WIDTH_LIM   = 2'd1;
	localparam logic [1:0] CFG_FIELD_WIDTH = 2'd2;
	localparam logic [1:0] CFG_RESULT_SIZE = 2'd3;
	localparam int         CFG_DATA_BITS   = 8;

	// conversion kinds
	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_OCT  = 3'd2;
	localparam logic [2:0] KIND_HEX  = 3'd3;
	localparam logic [2:0] KIND_AUTO = 3'd4;

	// result sizes
	localparam logic [1:0] RSZ_WORD = 2'd0;
	localparam logic [1:0] RSZ_HALF = 2'd1;
	localparam logic [1:0] RSZ_WIDE = 2'd2;

	// radix values
	localparam logic [4:0] RADIX_OCT = 5'd8;
	localparam logic [4:0] RADIX_DEC = 5'd10;
	localparam logic [4:0] RADIX_HEX = 5'd16;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	// scan phases
	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_PREFIX = 3'd2,
		PH_PFX_X  = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	// input transaction
	typedef struct packed {
		logic [7:0] character;
		logic       end_of_input;
	} item_t;

	// result transaction
	typedef struct packed {
		logic signed [31:0] value;
		logic               char_consumed;
		logic               status;
		logic [15:0]        chars_in_field;
	} result_t;

	// configuration registers
	typedef struct packed {
		logic [2:0] conversion_kind;
		logic       width_limited;
		logic [7:0] field_width;
		logic [1:0] result_size;
	} cfg_t;

	// scan state apart from the accumulator
	typedef struct packed {
		phase_t      phase;
		logic        is_negative;
		logic [7:0]  width_left;
		logic [4:0]  radix;
		logic [15:0] consumed_count;
	} scan_state_t;

endpackage

// ----- rtl/core/scif_step.sv -----
// ----------------------------------------------------------------------------
// scif_step
// Combinational scan step: takes one character against the current state and
// gives the next state and, when the field ends, the result.
// ----------------------------------------------------------------------------
module scif_step #(
	parameter int VALUE_BITS = scif_pkg::VALUE_BITS_DEF
) (
	input  scif_pkg::cfg_t          cfg,
	input  scif_pkg::item_t         item,
	input  scif_pkg::scan_state_t   cur,
	input  logic [VALUE_BITS-1:0]   acc,
	output scif_pkg::scan_state_t   nxt,
	output logic [VALUE_BITS-1:0]   acc_nxt,
	output logic                    emit,
	output scif_pkg::result_t       res
);
	import scif_pkg::*;

	logic [7:0] c;
	logic       blank;
	logic       is_x;
	logic [3:0] dval;
	logic       dok;

	// character classes
	assign c     = item.character;
	assign blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	assign is_x  = (c == CH_LO_X) || (c == CH_UP_X);

	// digit decode, dok low for non-digits
	always_comb begin
		dval = '0;
		dok  = 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			dval = 4'(c - CH_ZERO);
			dok  = 1'b1;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			dval = 4'(c - CH_LO_A + 8'd10);
			dok  = 1'b1;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			dval = 4'(c - CH_UP_A + 8'd10);
			dok  = 1'b1;
		end
	end

	// phase sequencing, accumulation and field end
	always_comb begin
		phase_t                ph;
		logic                  neg;
		logic [7:0]            wl;
		logic [4:0]            rad;
		logic [15:0]           cnt;
		logic [VALUE_BITS-1:0] a;
		logic [VALUE_BITS-1:0] mul;
		logic [VALUE_BITS-1:0] v;
		logic [63:0]           ext;
		logic                  stop;
		logic                  fin;
		logic                  tk;
		logic                  took;
		logic                  sts;

		ph   = cur.phase;
		neg  = cur.is_negative;
		wl   = cur.width_left;
		rad  = cur.radix;
		cnt  = cur.consumed_count;
		a    = acc;
		mul  = '0;
		stop = 1'b0;
		fin  = 1'b0;
		tk   = 1'b0;
		took = 1'b0;
		sts  = 1'b0;

		// leading white space
		if (ph == PH_SKIP) begin
			if (item.end_of_input) begin
				fin  = 1'b1;
				sts  = 1'b1;
				stop = 1'b1;
			end else if (blank) begin
				stop = 1'b1;
			end else begin
				wl = cfg.field_width;
				ph = PH_SIGN;
			end
		end

		// end of input or no width left
		if (!stop && (item.end_of_input || (cfg.width_limited && wl == 8'd0))) begin
			fin  = 1'b1;
			stop = 1'b1;
		end

		// optional minus sign
		if (!stop && ph == PH_SIGN) begin
			ph = PH_PREFIX;
			if (c == CH_MINUS) begin
				neg  = 1'b1;
				tk   = 1'b1;
				stop = 1'b1;
			end
		end

		// radix choice and leading zero of a prefix
		if (!stop && ph == PH_PREFIX) begin
			ph = PH_DIGITS;
			case (cfg.conversion_kind)
				KIND_OCT: begin
					rad = RADIX_OCT;
				end
				KIND_HEX: begin
					rad = RADIX_HEX;
					if (c == CH_ZERO) begin
						ph   = PH_PFX_X;
						tk   = 1'b1;
						stop = 1'b1;
					end
				end
				KIND_AUTO: begin
					rad = RADIX_DEC;
					if (c == CH_ZERO) begin
						rad  = RADIX_OCT;
						ph   = PH_PFX_X;
						tk   = 1'b1;
						stop = 1'b1;
					end
				end
				default: begin
					rad = RADIX_DEC;
				end
			endcase
		end

		// x after a leading zero
		if (!stop && ph == PH_PFX_X) begin
			ph = PH_DIGITS;
			if (is_x) begin
				rad  = RADIX_HEX;
				tk   = 1'b1;
				stop = 1'b1;
			end
		end

		// digit accumulation by shift and add
		if (rad == RADIX_HEX) begin
			mul = a << 4;
		end else if (rad == RADIX_OCT) begin
			mul = a << 3;
		end else begin
			mul = (a << 3) + (a << 1);
		end
		if (!stop) begin
			if (!dok || ({1'b0, dval} >= rad)) begin
				fin = 1'b1;
			end else begin
				a  = mul + VALUE_BITS'(dval);
				tk = 1'b1;
			end
		end

		// count the consumed character and check the width
		if (tk) begin
			if (cnt != 16'hffff) begin
				cnt = cnt + 16'd1;
			end
			if (cfg.width_limited) begin
				if (wl != 8'd0) begin
					wl = wl - 8'd1;
				end
				if (wl == 8'd0) begin
					fin  = 1'b1;
					took = 1'b1;
				end
			end
		end

		// result value, negated then sized
		v   = neg ? (~a + VALUE_BITS'(1)) : a;
		ext = 64'(signed'(v));
		if (cfg.result_size == RSZ_HALF) begin
			res.value = signed'({{16{ext[15]}}, ext[15:0]});
		end else begin
			res.value = signed'(ext[31:0]);
		end
		res.char_consumed  = took;
		res.status         = sts;
		res.chars_in_field = cnt;
		emit               = fin;

		// next state, cleared after a result
		if (fin) begin
			nxt.phase          = PH_SKIP;
			nxt.is_negative    = 1'b0;
			nxt.width_left     = '0;
			nxt.radix          = RADIX_DEC;
			nxt.consumed_count = '0;
			acc_nxt            = '0;
		end else begin
			nxt.phase          = ph;
			nxt.is_negative    = neg;
			nxt.width_left     = wl;
			nxt.radix          = rad;
			nxt.consumed_count = cnt;
			acc_nxt            = a;
		end
	end

endmodule

// ----- rtl/core/scif_out_buf.sv -----
// ----------------------------------------------------------------------------
// scif_out_buf
// Result register: holds one result transaction until it is taken, and can
// be reloaded in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module scif_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  scif_pkg::result_t load_data,
	output logic              can_load,
	output logic              result_valid,
	input  logic              result_ready,
	output scif_pkg::result_t result
);
	import scif_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free now or freed by this cycle's transaction
	assign can_load = !valid_q || result_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

// ----- rtl/core/scanf_integer_field_scanner.sv -----
// ----------------------------------------------------------------------------
// scanf_integer_field_scanner
// Scans one integer field of a character stream, one character per input
// transaction, and gives one result transaction when the field ends.
// ----------------------------------------------------------------------------
//  channel  signals                            direction  payload
//  item     item_valid / item_ready / item     in         item_t
//  result   result_valid / result_ready / result  out     result_t
//  config   cfg_we / cfg_index / cfg_data      in         4 registers
//
//  One character per cycle unless the step stage stalls: a transaction is
//  registered, then the scan step (shift-and-add accumulate, phase logic)
//  runs on it and writes the state and, at field end, the result register,
//  from which the result is then valid until it is taken.
//  Reset clears the scan state, configuration and both valid flags.
//  A held result stalls the step stage only while it is not taken.
// ----------------------------------------------------------------------------
module scanf_integer_field_scanner #(
	parameter int VALUE_BITS = scif_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  scif_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output scif_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [scif_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import scif_pkg::*;

	cfg_t                  cfg_q;
	item_t                 item_s1;
	logic                  valid_s1;
	scan_state_t           state_q;
	logic [VALUE_BITS-1:0] acc_q;
	scan_state_t           state_nxt;
	logic [VALUE_BITS-1:0] acc_nxt;
	logic                  emit;
	result_t               res;
	logic                  can_load;
	logic                  fire;

	// step stage advances when the result register can take its output
	assign fire       = valid_s1 && can_load;
	assign item_ready = !valid_s1 || fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KIND:        cfg_q.conversion_kind <= cfg_data[2:0];
				CFG_WIDTH_LIM:   cfg_q.width_limited   <= cfg_data[0];
				CFG_FIELD_WIDTH: cfg_q.field_width     <= cfg_data[7:0];
				CFG_RESULT_SIZE: cfg_q.result_size     <= cfg_data[1:0];
				default:         cfg_q                 <= cfg_q;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= PH_SKIP;
			state_q.is_negative    <= 1'b0;
			state_q.width_left     <= '0;
			state_q.radix          <= RADIX_DEC;
			state_q.consumed_count <= '0;
			acc_q                  <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
			acc_q   <= acc_nxt;
		end
	end

	scif_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.cfg     (cfg_q),
		.item    (item_s1),
		.cur     (state_q),
		.acc     (acc_q),
		.nxt     (state_nxt),
		.acc_nxt (acc_nxt),
		.emit    (emit),
		.res     (res)
	);

	scif_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && emit),
		.load_data    (res),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- test/scanf_integer_field_scanner_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanf_integer_field_scanner_test
// Self-checking bench for the integer field scanner. Character transactions
// go in over valid/ready with random gaps, and a scoreboard class predicts
// each field result. Every result is compared field by field in order.
// ----------------------------------------------------------------------------
module scanf_integer_field_scanner_test;
	import scif_pkg::*;

	// scoreboard: mirrors the scan state and holds the expected field results
	class field_scoreboard;
		cfg_t        cfg;
		phase_t      phase;
		logic [31:0] acc;
		bit          negative;
		logic [7:0]  width_left;
		logic [4:0]  radix;
		logic [15:0] taken;
		result_t     pending_fields[$];
		int          mismatches;
		int          results_seen;

		function new();
			cfg = '0;
			mismatches = 0;
			results_seen = 0;
			restart_field();
		endfunction

		function void restart_field();
			phase = PH_SKIP;
			acc = '0;
			negative = 1'b0;
			width_left = '0;
			radix = RADIX_DEC;
			taken = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				CFG_KIND:        cfg.conversion_kind = data[2:0];
				CFG_WIDTH_LIM:   cfg.width_limited = data[0];
				CFG_FIELD_WIDTH: cfg.field_width = data;
				CFG_RESULT_SIZE: cfg.result_size = data[1:0];
				default: ;
			endcase
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function logic [7:0] digit_value(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
			if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 8'd10;
			if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 8'd10;
			return 8'hff;
		endfunction

		// count one consumed character, true once the width is used up
		function bit count_char();
			if (taken != 16'hffff)
				taken++;
			if (cfg.width_limited) begin
				if (width_left != 0)
					width_left--;
				return width_left == 0;
			end
			return 1'b0;
		endfunction

		// queue the field result and start over
		function void close_field(bit took, bit ended_blank);
			result_t     r;
			logic [31:0] v;
			v = negative ? 32'd0 - acc : acc;
			if (cfg.result_size == RSZ_HALF)
				v = {{16{v[15]}}, v[15:0]};
			r.value = v;
			r.char_consumed = took;
			r.status = ended_blank;
			r.chars_in_field = taken;
			pending_fields.push_back(r);
			restart_field();
		endfunction

		// one scan step per accepted character transaction
		function void take_character(item_t it);
			logic [7:0] c;
			logic [7:0] d;
			c = it.character;
			if (phase == PH_SKIP) begin
				if (it.end_of_input) begin
					close_field(1'b0, 1'b1);
					return;
				end
				if (is_blank(c))
					return;
				width_left = cfg.field_width;
				phase = PH_SIGN;
			end
			if (it.end_of_input || (cfg.width_limited && width_left == 0)) begin
				close_field(1'b0, 1'b0);
				return;
			end
			if (phase == PH_SIGN) begin
				phase = PH_PREFIX;
				if (c == CH_MINUS) begin
					negative = 1'b1;
					if (count_char())
						close_field(1'b1, 1'b0);
					return;
				end
			end
			if (phase == PH_PREFIX) begin
				phase = PH_DIGITS;
				case (cfg.conversion_kind)
					KIND_OCT: radix = RADIX_OCT;
					KIND_HEX: begin
						radix = RADIX_HEX;
						if (c == CH_ZERO) begin
							phase = PH_PFX_X;
							if (count_char())
								close_field(1'b1, 1'b0);
							return;
						end
					end
					KIND_AUTO: begin
						radix = RADIX_DEC;
						if (c == CH_ZERO) begin
							radix = RADIX_OCT;
							phase = PH_PFX_X;
							if (count_char())
								close_field(1'b1, 1'b0);
							return;
						end
					end
					default: radix = RADIX_DEC;
				endcase
			end
			if (phase == PH_PFX_X) begin
				phase = PH_DIGITS;
				if (c == CH_LO_X || c == CH_UP_X) begin
					radix = RADIX_HEX;
					if (count_char())
						close_field(1'b1, 1'b0);
					return;
				end
			end
			d = digit_value(c);
			if (d >= radix) begin
				close_field(1'b0, 1'b0);
				return;
			end
			acc = acc * radix + d;
			if (count_char())
				close_field(1'b1, 1'b0);
		endfunction

		task report_mismatch(string what);
			if (mismatches < 30)
				$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending_fields.size() == 0) begin
				report_mismatch($sformatf("result %0d with none expected, value %0d",
					results_seen, got.value));
				return;
			end
			want = pending_fields.pop_front();
			if (got.value !== want.value)
				report_mismatch($sformatf("result %0d value %0d, expected %0d",
					results_seen, got.value, want.value));
			if (got.char_consumed !== want.char_consumed)
				report_mismatch($sformatf("result %0d char_consumed %0b, expected %0b",
					results_seen, got.char_consumed, want.char_consumed));
			if (got.status !== want.status)
				report_mismatch($sformatf("result %0d status %0b, expected %0b",
					results_seen, got.status, want.status));
			if (got.chars_in_field !== want.chars_in_field)
				report_mismatch($sformatf("result %0d chars_in_field %0d, expected %0d",
					results_seen, got.chars_in_field, want.chars_in_field));
		endtask

		task flag_leftovers();
			if (pending_fields.size() != 0)
				report_mismatch($sformatf("%0d field results never arrived",
					pending_fields.size()));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	field_scoreboard sb = new();
	bit              no_gaps = 1'b0;
	int              items_sent = 0;
	int              settings_used = 0;
	string           hex_digits = "0123456789abcdefABCDEF";

	scanf_integer_field_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// overall time limit
	initial begin
		#2000000;
		$display("[scanf_integer_field_scanner] ERROR");
		$finish;
	end

	function bit take_gap();
		return !no_gaps && ($urandom_range(99) < 30);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		result_ready <= arst_n && !take_gap();
	end

	// result transaction check
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// one character transaction; starts and ends at a falling edge
	task automatic send_char(input logic [7:0] c, input bit eoi);
		item_t next;
		next.character = c;
		next.end_of_input = eoi;
		while (take_gap()) begin
			item_valid = 1'b0;
			item.character = 8'($urandom);
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = next;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.take_character(next);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// stop sending and wait until every expected result is in or the limit is reached
	task automatic drain(input int limit);
		int n;
		n = 0;
		item_valid = 1'b0;
		while (sb.pending_fields.size() != 0 && n < limit) begin
			@(negedge clk);
			n++;
		end
		repeat (4) @(negedge clk);
	endtask

	// registers are only written once the scanner has gone quiet
	task automatic apply_settings(input logic [2:0] kind, input bit lim,
		input logic [7:0] fwidth, input logic [1:0] size);
		drain(100000);
		write_reg(CFG_KIND, {5'($urandom), kind});
		write_reg(CFG_WIDTH_LIM, {7'($urandom), lim});
		write_reg(CFG_FIELD_WIDTH, fwidth);
		write_reg(CFG_RESULT_SIZE, {6'($urandom), size});
		settings_used++;
	endtask

	function logic [7:0] blank_char();
		int r;
		r = $urandom_range(5);
		return r == 5 ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	// digit mostly valid for the current kind, now and then any hex digit
	function logic [7:0] digit_char();
		if ($urandom_range(9) == 0)
			return hex_digits[$urandom_range(21)];
		case (sb.cfg.conversion_kind)
			KIND_OCT:            return 8'(CH_ZERO + $urandom_range(7));
			KIND_HEX, KIND_AUTO: return hex_digits[$urandom_range(21)];
			default:             return 8'(CH_ZERO + $urandom_range(9));
		endcase
	endfunction

	// a field with random blanks, sign or plus, prefix, digits and end
	task automatic send_field();
		int r;
		int digits;
		repeat ($urandom_range(3))
			send_char(blank_char(), 1'b0);
		r = $urandom_range(99);
		if (r < 35)
			send_char(CH_MINUS, 1'b0);
		else if (r < 40)
			send_text("+");
		r = $urandom_range(9);
		if (r < 3) begin
			send_char(CH_ZERO, 1'b0);
			if (r < 2)
				send_char($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0);
		end
		digits = ($urandom_range(99) < 15) ? $urandom_range(10, 20) : $urandom_range(6);
		repeat (digits)
			send_char(digit_char(), 1'b0);
		r = $urandom_range(99);
		if (r < 30)
			send_char(8'($urandom), 1'b1);
		else if (r < 55)
			send_char(blank_char(), 1'b0);
		else
			send_char(8'($urandom), 1'b0);
	endtask

	function logic [7:0] phase_width(int p);
		case (p)
			0, 8:    return 8'd0;
			1, 7:    return 8'd255;
			2, 11:   return 8'd1;
			3:       return 8'd3;
			4:       return 8'd2;
			6:       return 8'd5;
			default: return 8'($urandom_range(1, 12));
		endcase
	endfunction

	// main sequence
	initial begin
		int phase_end;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		result_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: end while skipping, sign, plus sign, lone minus
		apply_settings(KIND_SDEC, 1'b0, 8'd0, RSZ_WORD);
		send_char(8'hff, 1'b1);
		send_text(" \t-12x");
		send_text("+");
		send_text("-");
		send_char(CH_ZERO, 1'b1);
		// zero width ends the field at once
		apply_settings(KIND_AUTO, 1'b1, 8'd0, RSZ_HALF);
		send_text("7");
		// auto base: hex prefix, octal zero, prefix with no digit
		apply_settings(KIND_AUTO, 1'b0, 8'd255, RSZ_HALF);
		send_text("0x1F ");
		send_text("017;");
		send_text("0X");
		send_char(CH_SPACE, 1'b1);
		// width runs out on the last hex letter
		apply_settings(KIND_HEX, 1'b1, 8'd2, RSZ_WIDE);
		send_text("fF");

		// random fields under a range of settings, two phases with no gaps
		for (int p = 0; p < 12; p++) begin
			apply_settings(p < 8 ? 3'(p) : 3'($urandom_range(4)), (p % 3) != 0,
				phase_width(p), 2'(p % 4));
			no_gaps = (p == 5 || p == 6);
			phase_end = items_sent + 70;
			while (items_sent < phase_end) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 3))
						send_char(8'($urandom), $urandom_range(9) == 0);
				else
					send_field();
			end
			send_char(8'($urandom), 1'b1);
		end
		no_gaps = 1'b0;

		drain(5000);
		repeat (10) @(negedge clk);
		sb.flag_leftovers();

		$display("run covered %0d character transactions and %0d field results",
			items_sent, sb.results_seen);
		$display("over %0d register settings, all kinds, sizes and width limits",
			settings_used);
		if (sb.mismatches == 0)
			$display("[scanf_integer_field_scanner] OK");
		else
			$display("[scanf_integer_field_scanner] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/scif_pkg.sv
rtl/core/scif_step.sv
rtl/core/scif_out_buf.sv
rtl/core/scanf_integer_field_scanner.sv
test/scanf_integer_field_scanner_test.sv
